FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the viewport scroll controller
// Concurrent checks with a clock and an optional synchronous reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, held off while reset is low
`define VSC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error(msg);

// Check a property on every rising edge, reset included
`define VSC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/vsc_pkg.sv
// ---------------------------------------------------------------------------
// vsc_pkg
// Command codes, register indexes and shared types of the scroll controller.
// ---------------------------------------------------------------------------
`default_nettype none

package vsc_pkg;

    localparam int CMD_W   = 4;
    localparam int CHAR_W  = 8;
    localparam int IN_W    = 16;
    localparam int LIM_W   = 32;
    localparam int STEP_W  = 9;
    localparam int DIGIT_W = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_ROWS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_COLUMNS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEQUENCE_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONGEST_LENGTH = 2'd3;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_NOTE_KEY    = 4'd0;
    localparam logic [CMD_W-1:0] CMD_RESET_ACCEL = 4'd1;
    localparam logic [CMD_W-1:0] CMD_STEP_DOWN   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_STEP_UP     = 4'd3;
    localparam logic [CMD_W-1:0] CMD_STEP_RIGHT  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_STEP_LEFT   = 4'd5;
    localparam logic [CMD_W-1:0] CMD_HALF_DOWN   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_HALF_UP     = 4'd7;
    localparam logic [CMD_W-1:0] CMD_HALF_RIGHT  = 4'd8;
    localparam logic [CMD_W-1:0] CMD_HALF_LEFT   = 4'd9;
    localparam logic [CMD_W-1:0] CMD_JUMP_START  = 4'd10;
    localparam logic [CMD_W-1:0] CMD_JUMP_CHAR   = 4'd11;
    localparam logic [CMD_W-1:0] CMD_JUMP_EXEC   = 4'd12;
    localparam logic [CMD_W-1:0] CMD_JUMP_CANCEL = 4'd13;
    localparam logic [CMD_W-1:0] CMD_RECLAMP     = 4'd14;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

    // Scroll limits derived from the configuration registers
    typedef struct packed {
        logic [LIM_W-1:0]  row_limit;
        logic [LIM_W-1:0]  col_limit;
        logic [STEP_W-1:0] half_rows;
        logic [STEP_W-1:0] half_cols;
    } t_limits;

endpackage

`default_nettype wire

FILE: design/vsc_cfg.sv
// ---------------------------------------------------------------------------
// vsc_cfg
// Configuration registers and the scroll limits that follow from them.
// ---------------------------------------------------------------------------
`default_nettype none

module vsc_cfg #(
    parameter int ROW_WIDTH = 16,
    parameter int COL_WIDTH = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [vsc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [vsc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output vsc_pkg::t_limits                   o_lim
);
    import vsc_pkg::*;

    localparam logic [LIM_W:0] ROW_MAX = (33'd1 << ROW_WIDTH) - 33'd1;
    localparam logic [LIM_W:0] COL_MAX = (33'd1 << COL_WIDTH) - 33'd1;

    logic [9:0]  r_screen_rows;
    logic [9:0]  r_screen_columns;
    logic [15:0] r_sequence_count;
    logic [23:0] r_longest_length;

    logic signed [17:0] row_span;
    logic [LIM_W:0]     row_free;
    logic [23:0]        col_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_rows    <= 10'd24;
            r_screen_columns <= 10'd80;
            r_sequence_count <= 16'd0;
            r_longest_length <= 24'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SCREEN_ROWS:    r_screen_rows    <= i_cfg_wdata[9:0];
                REG_SCREEN_COLUMNS: r_screen_columns <= i_cfg_wdata[9:0];
                REG_SEQUENCE_COUNT: r_sequence_count <= i_cfg_wdata[15:0];
                REG_LONGEST_LENGTH: r_longest_length <= i_cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    // Row limit: rows less the content rows (screen less ruler and status)
    assign row_span = $signed({2'b00, r_sequence_count}) - $signed({8'd0, r_screen_rows})
                    + 18'sd2;
    assign row_free = row_span[17] ? '0 : {16'd0, row_span[16:0]};
    assign col_last = (r_longest_length == 24'd0) ? 24'd0 : r_longest_length - 24'd1;

    always_comb begin
        o_lim.row_limit = (row_free > ROW_MAX) ? ROW_MAX[LIM_W-1:0] : row_free[LIM_W-1:0];
        o_lim.col_limit = ({9'd0, col_last} > COL_MAX) ? COL_MAX[LIM_W-1:0]
                                                       : {8'd0, col_last};
        o_lim.half_rows = (r_screen_rows >= 10'd4)
                        ? STEP_W'((r_screen_rows - 10'd2) >> 1) : STEP_W'(1);
        o_lim.half_cols = (r_screen_columns >= 10'd20)
                        ? STEP_W'((r_screen_columns - 10'd18) >> 1) : STEP_W'(1);
    end

endmodule

`default_nettype wire

FILE: design/vsc_engine.sv
// ---------------------------------------------------------------------------
// vsc_engine
// Viewport state registers and the next-state update for each command word.
// ---------------------------------------------------------------------------
`default_nettype none

module vsc_engine #(
    parameter int MAX_JUMP_DIGITS = 15,
    parameter int ROW_WIDTH       = 16,
    parameter int COL_WIDTH       = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic [vsc_pkg::CMD_W-1:0]     i_command,
    input  wire logic [vsc_pkg::CHAR_W-1:0]    i_key_char,
    input  wire vsc_pkg::t_limits              i_lim,
    output logic [ROW_WIDTH-1:0]               o_top_row,
    output logic [COL_WIDTH-1:0]               o_left_column,
    output logic [vsc_pkg::STEP_W-1:0]         o_step_size,
    output logic                               o_jump_active,
    output logic [COL_WIDTH-1:0]               o_jump_value,
    output logic [vsc_pkg::DIGIT_W-1:0]        o_jump_count
);
    import vsc_pkg::*;

    localparam int RS_W = ROW_WIDTH + 10;
    localparam int CS_W = COL_WIDTH + 10;
    localparam int JS_W = COL_WIDTH + 4;

    logic [ROW_WIDTH-1:0] r_row_offset, n_row_offset;
    logic [COL_WIDTH-1:0] r_col_offset, n_col_offset;
    logic [CHAR_W-1:0]    r_previous_key, n_previous_key;
    logic [4:0]           r_repeats, n_repeats;
    logic [STEP_W-1:0]    r_accel, n_accel;
    logic                 r_jump_open, n_jump_open;
    logic [DIGIT_W-1:0]   r_jump_digits, n_jump_digits;
    logic [COL_WIDTH-1:0] r_jump_accum, n_jump_accum;

    logic [ROW_WIDTH-1:0] lim_row;
    logic [COL_WIDTH-1:0] lim_col;
    logic                 step_cmd_v, step_cmd_h;
    logic [STEP_W-1:0]    amt_v, amt_h;
    logic [RS_W-1:0]      row_sum, row_diff;
    logic [CS_W-1:0]      col_sum, col_diff;
    logic [ROW_WIDTH-1:0] row_down, row_up;
    logic [COL_WIDTH-1:0] col_right, col_left;
    logic [4:0]           rep_inc;
    logic [JS_W-1:0]      jump_next;
    logic [COL_WIDTH-1:0] jump_sat, jump_target;
    logic                 digit_ok;

    assign lim_row = i_lim.row_limit[ROW_WIDTH-1:0];
    assign lim_col = i_lim.col_limit[COL_WIDTH-1:0];

    assign step_cmd_v = (i_command == CMD_STEP_DOWN) || (i_command == CMD_STEP_UP);
    assign step_cmd_h = (i_command == CMD_STEP_RIGHT) || (i_command == CMD_STEP_LEFT);
    assign amt_v = step_cmd_v ? r_accel : i_lim.half_rows;
    assign amt_h = step_cmd_h ? r_accel : i_lim.half_cols;

    // Move and clamp
    assign row_sum   = RS_W'(r_row_offset) + RS_W'(amt_v);
    assign row_down  = (row_sum > RS_W'(lim_row)) ? lim_row : row_sum[ROW_WIDTH-1:0];
    assign row_diff  = RS_W'(r_row_offset) - RS_W'(amt_v);
    assign row_up    = (RS_W'(amt_v) >= RS_W'(r_row_offset)) ? '0 : row_diff[ROW_WIDTH-1:0];
    assign col_sum   = CS_W'(r_col_offset) + CS_W'(amt_h);
    assign col_right = (col_sum > CS_W'(lim_col)) ? lim_col : col_sum[COL_WIDTH-1:0];
    assign col_diff  = CS_W'(r_col_offset) - CS_W'(amt_h);
    assign col_left  = (CS_W'(amt_h) >= CS_W'(r_col_offset)) ? '0 : col_diff[COL_WIDTH-1:0];

    assign rep_inc = (r_repeats == 5'd31) ? r_repeats : r_repeats + 5'd1;

    // Decimal digit: accum * 10 + digit, saturating at full scale
    assign digit_ok  = r_jump_open && (i_key_char >= CHAR_ZERO) && (i_key_char <= CHAR_NINE)
                     && (r_jump_digits < DIGIT_W'(MAX_JUMP_DIGITS));
    assign jump_next = (JS_W'(r_jump_accum) << 3) + (JS_W'(r_jump_accum) << 1)
                     + JS_W'(i_key_char[3:0]);
    assign jump_sat  = (jump_next[JS_W-1:COL_WIDTH] != '0) ? '1 : jump_next[COL_WIDTH-1:0];
    assign jump_target = r_jump_accum - COL_WIDTH'(1);

    always_comb begin
        n_row_offset   = r_row_offset;
        n_col_offset   = r_col_offset;
        n_previous_key = r_previous_key;
        n_repeats      = r_repeats;
        n_accel        = r_accel;
        n_jump_open    = r_jump_open;
        n_jump_digits  = r_jump_digits;
        n_jump_accum   = r_jump_accum;
        unique case (i_command) inside
            CMD_NOTE_KEY: begin
                n_previous_key = i_key_char;
                if (r_previous_key == i_key_char) begin
                    n_repeats = rep_inc;
                    if (rep_inc <= 5'd2)       n_accel = STEP_W'(1);
                    else if (rep_inc <= 5'd5)  n_accel = STEP_W'(16);
                    else if (rep_inc <= 5'd10) n_accel = STEP_W'(32);
                    else if (rep_inc <= 5'd20) n_accel = STEP_W'(64);
                    else                       n_accel = STEP_W'(256);
                end else begin
                    n_repeats = 5'd1;
                    n_accel   = STEP_W'(1);
                end
            end
            CMD_RESET_ACCEL: begin
                n_repeats      = 5'd0;
                n_accel        = STEP_W'(1);
                n_previous_key = '0;
            end
            CMD_STEP_DOWN, CMD_HALF_DOWN:   n_row_offset = row_down;
            CMD_STEP_UP, CMD_HALF_UP:       n_row_offset = row_up;
            CMD_STEP_RIGHT, CMD_HALF_RIGHT: n_col_offset = col_right;
            CMD_STEP_LEFT, CMD_HALF_LEFT:   n_col_offset = col_left;
            CMD_JUMP_START: begin
                n_jump_open   = 1'b1;
                n_jump_digits = '0;
                n_jump_accum  = '0;
            end
            CMD_JUMP_CHAR: begin
                if (digit_ok) begin
                    n_jump_accum  = jump_sat;
                    n_jump_digits = r_jump_digits + DIGIT_W'(1);
                end
            end
            CMD_JUMP_EXEC: begin
                if (r_jump_open) begin
                    if ((r_jump_digits != '0) && (r_jump_accum != '0)) begin
                        n_col_offset = (jump_target > lim_col) ? lim_col : jump_target;
                    end
                    n_jump_open   = 1'b0;
                    n_jump_digits = '0;
                    n_jump_accum  = '0;
                end
            end
            CMD_JUMP_CANCEL: begin
                n_jump_open   = 1'b0;
                n_jump_digits = '0;
                n_jump_accum  = '0;
            end
            CMD_RECLAMP: begin
                if (r_row_offset > lim_row) n_row_offset = lim_row;
                if (r_col_offset > lim_col) n_col_offset = lim_col;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_offset   <= '0;
            r_col_offset   <= '0;
            r_previous_key <= '0;
            r_repeats      <= '0;
            r_accel        <= STEP_W'(1);
            r_jump_open    <= 1'b0;
            r_jump_digits  <= '0;
            r_jump_accum   <= '0;
        end else if (i_en) begin
            r_row_offset   <= n_row_offset;
            r_col_offset   <= n_col_offset;
            r_previous_key <= n_previous_key;
            r_repeats      <= n_repeats;
            r_accel        <= n_accel;
            r_jump_open    <= n_jump_open;
            r_jump_digits  <= n_jump_digits;
            r_jump_accum   <= n_jump_accum;
        end
    end

    // Present the state as it stands after this word
    assign o_top_row     = n_row_offset;
    assign o_left_column = n_col_offset;
    assign o_step_size   = n_accel;
    assign o_jump_active = n_jump_open;
    assign o_jump_value  = n_jump_accum;
    assign o_jump_count  = n_jump_digits;

endmodule

`default_nettype wire

FILE: design/viewport_scroll_controller_core.sv
// ---------------------------------------------------------------------------
// viewport_scroll_controller_core
// Row and column offsets of a viewport, driven by scroll and jump commands.
// ---------------------------------------------------------------------------
// Takes one command word per cycle while the result side is not stalled and
// returns one result word per command, holding the viewport state after that
// command. A word passes the input register, then the result register; throughput
// is one word per cycle without back-pressure, set by the update loop of the
// offset, step and jump registers. Configuration writes are expected only while no
// word is in flight; the derived scroll limits follow the registers with no delay.
`default_nettype none

`include "assert_macros.svh"

module viewport_scroll_controller_core #(
    parameter int MAX_JUMP_DIGITS = 15,
    parameter int ROW_WIDTH       = 16,
    parameter int COL_WIDTH       = 24,
    localparam int OUT_BITS       = ROW_WIDTH + 2 * COL_WIDTH + 14,
    localparam int OUT_W          = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [vsc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [vsc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // command [3:0], key_char [11:4], zero [15:12]
    input  wire logic [vsc_pkg::IN_W-1:0]       i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // top_row, left_column, step_size, jump_active, jump_value, jump_count,
    // then zero fill
    output logic [OUT_W-1:0]                    o_m_axis_tdata
);
    import vsc_pkg::*;

    t_limits lim;

    logic              r_in_valid;
    logic [CMD_W-1:0]  r_in_command;
    logic [CHAR_W-1:0] r_in_char;
    logic              adv_out, adv_in;

    logic [ROW_WIDTH-1:0] eng_row;
    logic [COL_WIDTH-1:0] eng_col, eng_jacc;
    logic [STEP_W-1:0]    eng_accel;
    logic                 eng_jopen;
    logic [DIGIT_W-1:0]   eng_jdig;

    logic                 r_out_valid;
    logic [ROW_WIDTH-1:0] r_out_row;
    logic [COL_WIDTH-1:0] r_out_col, r_out_jacc;
    logic [STEP_W-1:0]    r_out_accel;
    logic                 r_out_jopen;
    logic [DIGIT_W-1:0]   r_out_jdig;

    vsc_cfg #(
        .ROW_WIDTH(ROW_WIDTH),
        .COL_WIDTH(COL_WIDTH)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .o_lim      (lim)
    );

    // Result register frees when empty or taken; input register behind it
    assign adv_out = !r_out_valid || i_m_axis_tready;
    assign adv_in  = !r_in_valid || adv_out;
    assign o_s_axis_tready = adv_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (adv_in) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_in && i_s_axis_tvalid) begin
            r_in_command <= i_s_axis_tdata[CMD_W-1:0];
            r_in_char    <= i_s_axis_tdata[CMD_W+CHAR_W-1:CMD_W];
        end
    end

    vsc_engine #(
        .MAX_JUMP_DIGITS(MAX_JUMP_DIGITS),
        .ROW_WIDTH      (ROW_WIDTH),
        .COL_WIDTH      (COL_WIDTH)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (r_in_valid && adv_out),
        .i_command    (r_in_command),
        .i_key_char   (r_in_char),
        .i_lim        (lim),
        .o_top_row    (eng_row),
        .o_left_column(eng_col),
        .o_step_size  (eng_accel),
        .o_jump_active(eng_jopen),
        .o_jump_value (eng_jacc),
        .o_jump_count (eng_jdig)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && r_in_valid) begin
            r_out_row   <= eng_row;
            r_out_col   <= eng_col;
            r_out_accel <= eng_accel;
            r_out_jopen <= eng_jopen;
            r_out_jacc  <= eng_jacc;
            r_out_jdig  <= eng_jdig;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'({r_out_jdig, r_out_jacc, r_out_jopen, r_out_accel,
                                     r_out_col, r_out_row});

    `VSC_ASSERT(a_step_legal, i_clk, i_rst_n,
        r_out_valid |-> (r_out_accel == 9'd1 || r_out_accel == 9'd16 ||
                         r_out_accel == 9'd32 || r_out_accel == 9'd64 ||
                         r_out_accel == 9'd256),
        "step size off the acceleration ladder")
    `VSC_ASSERT(a_jump_closed_clear, i_clk, i_rst_n,
        (r_out_valid && !r_out_jopen) |-> (r_out_jdig == '0 && r_out_jacc == '0),
        "jump digits left behind with jump entry closed")
    `VSC_ASSERT(a_jump_count_cap, i_clk, i_rst_n,
        r_out_valid |-> (r_out_jdig <= DIGIT_W'(MAX_JUMP_DIGITS)),
        "jump digit count past its cap")
    `VSC_ASSERT(a_word_moves_on, i_clk, i_rst_n,
        (r_in_valid && adv_out) |=> r_out_valid,
        "word in the input register lost on its way to the result register")
    `VSC_ASSERT_ALWAYS(a_reset_empty, i_clk,
        !i_rst_n |=> (!r_out_valid && !r_in_valid),
        "pipeline holds a word after reset")

endmodule

`default_nettype wire
